FILE: rtl/ifmt_pkg.sv
// Shared types, codes and helper functions for the integer field formatter.
// No dependencies; every other file in rtl/ imports this package.

package ifmt_pkg;

    localparam int NUM_DIGITS = 22;
    localparam int BCD_DIGITS = 20;
    localparam int RESULT_CAP = 64;
    localparam int POS_W      = 7;
    localparam int LEN_W      = 8;

    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_OCT  = 3'd2;
    localparam logic [2:0] CMD_HEXL = 3'd3;
    localparam logic [2:0] CMD_HEXU = 3'd4;
    localparam logic [2:0] CMD_PTR  = 3'd5;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_H    = 2'd1;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_XLOW  = 8'h78;
    localparam logic [7:0] CH_XUP   = 8'h58;
    localparam logic [7:0] CH_ALOW  = 8'h61;
    localparam logic [7:0] CH_AUP   = 8'h41;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] length_mod;
        logic       flag_left;
        logic       flag_plus;
        logic       flag_space;
        logic       flag_zero;
        logic       flag_alt;
        logic [6:0] field_width;
        logic       precision_given;
        logic [5:0] min_digits;
    } req_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic digits;
        logic count;
        logic plan;
        logic layout;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_dec;
        logic out_free;
        logic emit_last;
    } ctl_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base_ch;
        base_ch = upper ? CH_AUP : CH_ALOW;
        if (d < 4'd10)
            digit_char = CH_ZERO + {4'd0, d};
        else
            digit_char = base_ch + {4'd0, d} - 8'd10;
    endfunction

    function automatic logic [3:0] bcd_adjust(input logic [3:0] n);
        bcd_adjust = (n >= 4'd5) ? n + 4'd3 : n;
    endfunction

endpackage

FILE: rtl/ifmt_ctrl.sv
// Sequencing controller for the integer field formatter.
// Depends on ifmt_pkg; drives the datapath through ctl_cmd_t and reads ctl_stat_t.

module ifmt_ctrl
    import ifmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONV   = 3'd1;
    localparam logic [2:0] S_DIGITS = 3'd2;
    localparam logic [2:0] S_COUNT  = 3'd3;
    localparam logic [2:0] S_PLAN   = 3'd4;
    localparam logic [2:0] S_LAYOUT = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = stat.in_dec ? S_CONV : S_DIGITS;
                end
            end
            S_CONV:
            begin
                cmd.conv  = 1'b1;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63)
                    state_next = S_DIGITS;
            end
            S_DIGITS:
            begin
                cmd.digits = 1'b1;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = S_PLAN;
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = S_LAYOUT;
            end
            S_LAYOUT:
            begin
                cmd.layout = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: rtl/ifmt_dp.sv
// Datapath for the integer field formatter: magnitude, BCD conversion, digit store,
// field layout and the output register. Depends on ifmt_pkg; steered by ifmt_ctrl.

module ifmt_dp
    import ifmt_pkg::*;
#(
    parameter int MAX_FIELD = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    output ctl_stat_t   stat,
    input  req_t        req,
    input  logic [63:0] raw_value,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    localparam int CAP = (MAX_FIELD < RESULT_CAP) ? MAX_FIELD : RESULT_CAP;
    localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAP);

    req_t                  req_reg;
    logic [63:0]           mag_reg;
    logic                  neg_reg;
    logic                  mag_zero_reg;
    logic [4*BCD_DIGITS-1:0] bcd_reg;
    logic [4*NUM_DIGITS-1:0] dig_reg;
    logic [4:0]            ndig_reg;
    logic [5:0]            zeros_reg;
    logic                  has_sign_reg;
    logic [7:0]            sign_char_reg;
    logic [1:0]            npre_reg;
    logic [7:0]            pre_char_reg;
    logic [LEN_W-1:0]      body_reg;
    logic [LEN_W-1:0]      e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, total_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_char_reg;
    logic                  out_last_reg;
    logic                  out_empty_reg;

    logic [63:0]           ext;
    logic                  neg_in;
    logic [63:0]           mag_in;
    logic [4*BCD_DIGITS-1:0] bcd_adj;
    logic [4*NUM_DIGITS-1:0] dig_next;
    logic [65:0]           oct_src;
    logic [4:0]            hi_digit;
    logic [4:0]            ndig_next;
    logic [5:0]            ndig6;
    logic [5:0]            zeros_next;
    logic                  has_sign_next;
    logic [7:0]            sign_char_next;
    logic [1:0]            npre_next;
    logic [LEN_W-1:0]      width_l, pad, lead, zpad, trail;
    logic [LEN_W-1:0]      e1, e2, e3, e4, e5, total, total_c;
    logic                  zero_fill;
    logic [LEN_W-1:0]      k;
    logic [4:0]            didx;
    logic [7:0]            emit_char;
    logic                  emit_empty;
    logic                  emit_last;

    // Truncate, extend and take the magnitude of the incoming argument
    always_comb
    begin
        if (req.cmd == CMD_PTR || req.length_mod[1])
            ext = raw_value;
        else if (req.length_mod == LEN_H)
            ext = (req.cmd == CMD_SDEC) ? {{48{raw_value[15]}}, raw_value[15:0]}
                                        : {48'd0, raw_value[15:0]};
        else
            ext = (req.cmd == CMD_SDEC) ? {{32{raw_value[31]}}, raw_value[31:0]}
                                        : {32'd0, raw_value[31:0]};
        neg_in = (req.cmd == CMD_SDEC) && ext[63];
        mag_in = neg_in ? (~ext + 64'd1) : ext;
    end

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
            bcd_adj[i*4 +: 4] = bcd_adjust(bcd_reg[i*4 +: 4]);
    end

    always_comb
    begin
        oct_src = {2'b00, mag_reg};
        case (req_reg.cmd) inside
            CMD_SDEC, CMD_UDEC:
                dig_next = {8'd0, bcd_reg};
            CMD_OCT:
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                    dig_next[i*4 +: 4] = {1'b0, oct_src[i*3 +: 3]};
            end
            default:
                dig_next = {24'd0, mag_reg};
        endcase
    end

    always_comb
    begin
        hi_digit = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
            if (dig_reg[i*4 +: 4] != 4'd0)
                hi_digit = 5'(i + 1);
        if (mag_zero_reg && req_reg.precision_given && req_reg.min_digits == 6'd0
            && req_reg.cmd != CMD_PTR)
            ndig_next = '0;
        else
            ndig_next = (hi_digit == 5'd0) ? 5'd1 : hi_digit;
    end

    always_comb
    begin
        ndig6 = {1'b0, ndig_reg};
        if (req_reg.precision_given && req_reg.min_digits > ndig6)
            zeros_next = req_reg.min_digits - ndig6;
        else
            zeros_next = '0;
        if (req_reg.cmd == CMD_OCT && req_reg.flag_alt && zeros_next == 6'd0
            && (ndig_reg == 5'd0 || !mag_zero_reg))
            zeros_next = 6'd1;

        has_sign_next  = 1'b0;
        sign_char_next = CH_SPACE;
        if (req_reg.cmd == CMD_SDEC)
        begin
            if (neg_reg)
            begin
                has_sign_next  = 1'b1;
                sign_char_next = CH_MINUS;
            end
            else if (req_reg.flag_plus)
            begin
                has_sign_next  = 1'b1;
                sign_char_next = CH_PLUS;
            end
            else if (req_reg.flag_space)
            begin
                has_sign_next  = 1'b1;
            end
        end

        if (req_reg.cmd == CMD_PTR || ((req_reg.cmd == CMD_HEXL || req_reg.cmd == CMD_HEXU)
            && req_reg.flag_alt && !mag_zero_reg))
            npre_next = 2'd2;
        else
            npre_next = 2'd0;
    end

    always_comb
    begin
        width_l   = {1'b0, req_reg.field_width};
        pad       = (width_l > body_reg) ? width_l - body_reg : '0;
        zero_fill = !req_reg.flag_left && req_reg.flag_zero && !req_reg.precision_given;
        lead      = (!req_reg.flag_left && !zero_fill) ? pad : '0;
        zpad      = zero_fill ? pad : '0;
        trail     = req_reg.flag_left ? pad : '0;
        e1        = lead;
        e2        = e1 + LEN_W'(has_sign_reg);
        e3        = e2 + LEN_W'(npre_reg);
        e4        = e3 + zpad + LEN_W'(zeros_reg);
        e5        = e4 + LEN_W'(ndig_reg);
        total     = (req_reg.cmd > CMD_PTR) ? '0 : e5 + trail;
        total_c   = (total > CAP_L) ? CAP_L : total;
    end

    always_comb
    begin
        k          = {1'b0, pos_reg};
        didx       = 5'(e5_reg - 8'd1 - k);
        emit_empty = (total_reg == '0);
        emit_last  = emit_empty || (k + 8'd1 == total_reg);
        if (k < e1_reg)
            emit_char = CH_SPACE;
        else if (k < e2_reg)
            emit_char = sign_char_reg;
        else if (k < e3_reg)
            emit_char = (k == e2_reg) ? CH_ZERO : pre_char_reg;
        else if (k < e4_reg)
            emit_char = CH_ZERO;
        else if (k < e5_reg)
            emit_char = digit_char(dig_reg[{didx, 2'b00} +: 4], req_reg.cmd == CMD_HEXU);
        else
            emit_char = CH_SPACE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req;
            mag_reg      <= mag_in;
            neg_reg      <= neg_in;
            mag_zero_reg <= (ext == 64'd0);
            bcd_reg      <= '0;
        end
        if (cmd.conv)
        begin
            bcd_reg <= {bcd_adj[4*BCD_DIGITS-2:0], mag_reg[63]};
            mag_reg <= {mag_reg[62:0], 1'b0};
        end
        if (cmd.digits)
            dig_reg <= dig_next;
        if (cmd.count)
            ndig_reg <= ndig_next;
        if (cmd.plan)
        begin
            zeros_reg     <= zeros_next;
            has_sign_reg  <= has_sign_next;
            sign_char_reg <= sign_char_next;
            npre_reg      <= npre_next;
            pre_char_reg  <= (req_reg.cmd == CMD_HEXU) ? CH_XUP : CH_XLOW;
            body_reg      <= LEN_W'(has_sign_next) + LEN_W'(npre_next)
                             + LEN_W'(zeros_next) + LEN_W'(ndig_reg);
        end
        if (cmd.layout)
        begin
            e1_reg    <= e1;
            e2_reg    <= e2;
            e3_reg    <= e3;
            e4_reg    <= e4;
            e5_reg    <= e5;
            total_reg <= total_c;
        end
        if (cmd.emit)
        begin
            out_char_reg  <= emit_empty ? 8'd0 : emit_char;
            out_last_reg  <= emit_last;
            out_empty_reg <= emit_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.layout)
                pos_reg <= '0;
            else if (cmd.emit)
                pos_reg <= pos_reg + 7'd1;
        end
    end

    assign stat.in_dec    = (req.cmd == CMD_SDEC) || (req.cmd == CMD_UDEC);
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.emit_last = emit_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

endmodule

FILE: rtl/integer_field_formatter.sv
// Top level of the integer field formatter: stream ports, field unpacking,
// controller and datapath. Depends on ifmt_pkg, ifmt_ctrl and ifmt_dp.
//
// One request arrives as one transfer on the s_ channel: conversion kind and
// length in s_tuser, the value, flags, width and precision in s_tdata. The
// formatted field leaves on the m_ channel one ASCII character per transfer,
// with m_tlast on the final character. A field with no characters gives one
// transfer with m_tuser set, m_tlast set and m_tdata zero.
// The accepting cycle loads the request; decimal kinds then run the shift-and-add-3
// binary to BCD loop, then every kind passes the setup steps digit capture, digit
// count, sizing and layout before the first character is loaded, then one
// character per cycle follows while m_tready is high.
// A field holds at most min(MAX_FIELD, 64) characters.
// One request is worked at a time; s_tready is high only between requests and
// rises while the last character may still wait in the output register.
// A stalled receiver holds the output register and pauses emission.
// Reset clears the controller and the output valid; the block then waits idle.

module integer_field_formatter
    import ifmt_pkg::*;
#(
    parameter int MAX_FIELD = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [63:0] raw_value, [64] flag_left, [65] flag_plus, [66] flag_space,
    // [67] flag_zero, [68] flag_alt, [75:69] field_width, [76] precision_given,
    // [82:77] min_digits, [87:83] zero
    input  logic [87:0] s_tdata,
    // [2:0] cmd, [4:3] length_mod
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_char
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // [0] empty_field
    output logic        m_tuser
);

    req_t      req;
    ctl_cmd_t  ctl_cmd;
    ctl_stat_t ctl_stat;

    assign req.cmd             = s_tuser[2:0];
    assign req.length_mod      = s_tuser[4:3];
    assign req.flag_left       = s_tdata[64];
    assign req.flag_plus       = s_tdata[65];
    assign req.flag_space      = s_tdata[66];
    assign req.flag_zero       = s_tdata[67];
    assign req.flag_alt        = s_tdata[68];
    assign req.field_width     = s_tdata[75:69];
    assign req.precision_given = s_tdata[76];
    assign req.min_digits      = s_tdata[82:77];

    ifmt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (ctl_stat),
        .cmd      (ctl_cmd)
    );

    ifmt_dp #(
        .MAX_FIELD (MAX_FIELD)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .stat      (ctl_stat),
        .req       (req),
        .raw_value (s_tdata[63:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request is in progress");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty field transfer not marked last or not zero");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("output transfer changed while the receiver stalled");

endmodule

FILE: test/integer_field_formatter_test.sv
// Self-checking testbench for integer_field_formatter: predicts each formatted field
// and compares every character transfer, with random idling on both stream sides.
// Depends on ifmt_pkg and the integer_field_formatter RTL.

module integer_field_formatter_test;
    import ifmt_pkg::*;

    localparam logic [2:0] CMD_BAD6   = 3'd6;
    localparam logic [2:0] CMD_BAD7   = 3'd7;
    localparam logic [1:0] LEN_L      = 2'd2;
    localparam logic [1:0] LEN_WIDE3  = 2'd3;
    localparam logic [4:0] FL_NONE    = 5'b00000;
    localparam logic [4:0] FL_LEFT    = 5'b00001;
    localparam logic [4:0] FL_PLUS    = 5'b00010;
    localparam logic [4:0] FL_SPACE   = 5'b00100;
    localparam logic [4:0] FL_ZERO    = 5'b01000;
    localparam logic [4:0] FL_ALT     = 5'b10000;
    localparam int         FIELD_CAP  = 64;
    localparam int         IDLE_PCT   = 31;
    localparam int         SETTLE     = 200;
    localparam int         CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0]  kind;
        logic [1:0]  len;
        logic [63:0] arg;
        logic        left;
        logic        plus;
        logic        space;
        logic        zero;
        logic        alt;
        logic [6:0]  width;
        logic        prec_given;
        logic [5:0]  prec;
    } conv_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } field_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    field_char_t expected_chars[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          hold_off_request = 0;
    int          hold_off_left = 0;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;

    integer_field_formatter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void predict_field(input conv_req_t r);
        logic [63:0] mag;
        logic [63:0] rest;
        logic [63:0] radix;
        logic [3:0]  digits [NUM_DIGITS];
        logic [7:0]  text [$];
        logic [7:0]  sign_ch;
        logic [7:0]  x_ch;
        field_char_t c;
        int          ndig;
        int          nzero;
        int          npre;
        int          body;
        int          pad;
        int          n;
        int          i;
        bit          zero_fill;
        sign_ch = 8'd0;
        npre = 0;
        if (r.kind <= CMD_PTR) begin
            if (r.kind == CMD_PTR || r.len >= LEN_L)
                mag = r.arg;
            else if (r.len == LEN_H)
                mag = (r.kind == CMD_SDEC) ? {{48{r.arg[15]}}, r.arg[15:0]}
                                           : {48'd0, r.arg[15:0]};
            else
                mag = (r.kind == CMD_SDEC) ? {{32{r.arg[31]}}, r.arg[31:0]}
                                           : {32'd0, r.arg[31:0]};
            if (r.kind == CMD_SDEC && mag[63]) begin
                sign_ch = CH_MINUS;
                mag = ~mag + 64'd1;
            end
            else if (r.kind == CMD_SDEC && r.plus)
                sign_ch = CH_PLUS;
            else if (r.kind == CMD_SDEC && r.space)
                sign_ch = CH_SPACE;
            radix = (r.kind <= CMD_UDEC) ? 64'd10 : (r.kind == CMD_OCT) ? 64'd8 : 64'd16;
            rest = mag;
            ndig = 0;
            do begin
                digits[ndig] = 4'(rest % radix);
                ndig++;
                rest = rest / radix;
            end while (rest != 0 && ndig < NUM_DIGITS);
            if (mag == 0 && r.prec_given && r.prec == 0 && r.kind != CMD_PTR)
                ndig = 0;
            nzero = (r.prec_given && r.prec > ndig) ? r.prec - ndig : 0;
            if (r.kind == CMD_OCT && r.alt && nzero == 0 && (ndig == 0 || mag != 0))
                nzero = 1;
            if (r.kind == CMD_PTR ||
                ((r.kind == CMD_HEXL || r.kind == CMD_HEXU) && r.alt && mag != 0))
                npre = 2;
            x_ch = (r.kind == CMD_HEXU) ? CH_XUP : CH_XLOW;
            body = ((sign_ch != 0) ? 1 : 0) + npre + nzero + ndig;
            pad = (r.width > body) ? r.width - body : 0;
            zero_fill = !r.left && r.zero && !r.prec_given;
            if (!r.left && !zero_fill)
                repeat (pad) text.push_back(CH_SPACE);
            if (sign_ch != 0)
                text.push_back(sign_ch);
            if (npre == 2) begin
                text.push_back(CH_ZERO);
                text.push_back(x_ch);
            end
            if (zero_fill)
                repeat (pad) text.push_back(CH_ZERO);
            repeat (nzero) text.push_back(CH_ZERO);
            for (i = ndig - 1; i >= 0; i--) begin
                if (digits[i] < 4'd10)
                    text.push_back(CH_ZERO + 8'(digits[i]));
                else
                    text.push_back(((r.kind == CMD_HEXU) ? CH_AUP : CH_ALOW)
                                   + 8'(digits[i]) - 8'd10);
            end
            if (r.left)
                repeat (pad) text.push_back(CH_SPACE);
        end
        if (text.size() == 0) begin
            c.ch = 8'd0;
            c.last = 1'b1;
            c.empty = 1'b1;
            expected_chars.push_back(c);
        end
        else begin
            n = (text.size() > FIELD_CAP) ? FIELD_CAP : text.size();
            for (i = 0; i < n; i++) begin
                c.ch = text[i];
                c.last = (i == n - 1);
                c.empty = 1'b0;
                expected_chars.push_back(c);
            end
        end
    endfunction

    function automatic conv_req_t make_req(input logic [2:0] kind, input logic [1:0] len,
                                           input logic [63:0] arg, input logic [4:0] flags,
                                           input logic [6:0] width, input logic prec_given,
                                           input logic [5:0] prec);
        conv_req_t r;
        r.kind = kind;
        r.len = len;
        r.arg = arg;
        r.left = flags[0];
        r.plus = flags[1];
        r.space = flags[2];
        r.zero = flags[3];
        r.alt = flags[4];
        r.width = width;
        r.prec_given = prec_given;
        r.prec = prec;
        return r;
    endfunction

    function automatic logic [63:0] pick_arg();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return {64{1'b1}};
            2: return 64'd1 << $urandom_range(63);
            3: return (64'd1 << $urandom_range(63)) - 64'd1;
            4: return 64'($urandom_range(999));
            5: return -64'($urandom_range(999));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic conv_req_t random_request();
        conv_req_t r;
        int sel;
        r.kind = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        r.len = 2'($urandom_range(3));
        r.arg = pick_arg();
        r.left = $urandom_range(99) < 30;
        r.plus = $urandom_range(99) < 30;
        r.space = $urandom_range(99) < 30;
        r.zero = $urandom_range(99) < 35;
        r.alt = $urandom_range(99) < 50;
        sel = $urandom_range(99);
        r.width = (sel < 70) ? 7'($urandom_range(20)) :
                  (sel < 95) ? 7'($urandom_range(64, 21)) : 7'($urandom_range(127, 65));
        r.prec_given = $urandom_range(1);
        r.prec = ($urandom_range(99) < 85) ? 6'($urandom_range(25)) : 6'($urandom_range(63, 26));
        return r;
    endfunction

    task automatic send_request(input conv_req_t r);
        while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, r.prec, r.prec_given, r.width, r.alt, r.zero, r.space, r.plus,
                    r.left, r.arg};
        s_tuser <= {r.len, r.kind};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_field(r);
    endtask

    task automatic drain_fields();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input field_char_t want,
                                   input logic [7:0] got_ch, input logic got_last,
                                   input logic got_empty);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected char %h last %b empty %b, got char %h last %b empty %b",
                     what, want.ch, want.last, want.empty, got_ch, got_last, got_empty);
    endtask

    always @(posedge clk)
    begin : check_output
        field_char_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                want.ch = 8'd0;
                want.last = 1'b0;
                want.empty = 1'b0;
                report_mismatch("unexpected transfer", want, m_tdata, m_tlast, m_tuser);
            end
            else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last || m_tuser !== want.empty)
                    report_mismatch("wrong field", want, m_tdata, m_tlast, m_tuser);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_request > 0) begin
            hold_off_left = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(receiver_idles && $urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("integer_field_formatter_test failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(make_req(CMD_SDEC, LEN_NONE, 64'h8000_0000, FL_NONE, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_SDEC, LEN_H, 64'hFFFF, FL_PLUS, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_SDEC, LEN_L, 64'h8000_0000_0000_0000, FL_NONE, 7'd0,
                              1'b0, 6'd0));
        send_request(make_req(CMD_SDEC, LEN_NONE, 64'd0, FL_NONE, 7'd0, 1'b1, 6'd0));
        send_request(make_req(CMD_UDEC, LEN_NONE, 64'd0, FL_NONE, 7'd5, 1'b1, 6'd0));
        send_request(make_req(CMD_HEXL, LEN_NONE, 64'd0, FL_ALT, 7'd0, 1'b1, 6'd0));
        send_request(make_req(CMD_OCT, LEN_NONE, 64'd0, FL_ALT, 7'd0, 1'b1, 6'd0));
        send_request(make_req(CMD_PTR, LEN_NONE, 64'd0, FL_NONE, 7'd0, 1'b1, 6'd0));
        send_request(make_req(CMD_SDEC, LEN_NONE, 64'd42, FL_PLUS | FL_SPACE, 7'd6, 1'b0, 6'd0));
        send_request(make_req(CMD_SDEC, LEN_NONE, 64'd42, FL_SPACE, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_UDEC, LEN_NONE, 64'd42, FL_PLUS | FL_SPACE, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_HEXL, LEN_NONE, 64'hDEAD_BEEF, FL_ALT | FL_ZERO, 7'd14,
                              1'b0, 6'd0));
        send_request(make_req(CMD_HEXU, LEN_L, {64{1'b1}}, FL_ALT, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_OCT, LEN_L, {64{1'b1}}, FL_ALT, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_OCT, LEN_NONE, 64'd8, FL_ALT, 7'd0, 1'b1, 6'd3));
        send_request(make_req(CMD_SDEC, LEN_NONE, -64'd5, FL_ZERO, 7'd8, 1'b0, 6'd0));
        send_request(make_req(CMD_SDEC, LEN_NONE, -64'd5, FL_ZERO | FL_LEFT, 7'd8, 1'b0, 6'd0));
        send_request(make_req(CMD_SDEC, LEN_NONE, -64'd5, FL_ZERO, 7'd8, 1'b1, 6'd3));
        send_request(make_req(CMD_PTR, LEN_H, 64'h1234, FL_LEFT, 7'd16, 1'b1, 6'd8));
        send_request(make_req(CMD_UDEC, LEN_WIDE3, {64{1'b1}}, FL_NONE, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_BAD6, LEN_NONE, 64'd1, FL_NONE, 7'd0, 1'b0, 6'd0));
        send_request(make_req(CMD_BAD7, LEN_L, 64'd1, FL_ZERO, 7'd10, 1'b0, 6'd0));
        send_request(make_req(CMD_UDEC, LEN_NONE, 64'd7, FL_NONE, 7'd127, 1'b0, 6'd0));
        send_request(make_req(CMD_HEXL, LEN_NONE, 64'd1, FL_ALT, 7'd0, 1'b1, 6'd63));
        send_request(make_req(CMD_UDEC, LEN_H, 64'h12345, FL_LEFT, 7'd64, 1'b0, 6'd0));
        drain_fields();
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_request(random_request());
        drain_fields();
    endtask

    task automatic test_backpressure();
        hold_off_request = 400;
        repeat (12) send_request(random_request());
        drain_fields();
    endtask

    task automatic test_full_rate();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        repeat (50) send_request(random_request());
        drain_fields();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(110);
        test_backpressure();
        test_full_rate();
        test_random_mix(40);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("integer_field_formatter_test passed");
        else
            $display("integer_field_formatter_test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ifmt_pkg.sv
rtl/ifmt_ctrl.sv
rtl/ifmt_dp.sv
rtl/integer_field_formatter.sv
test/integer_field_formatter_test.sv
